/* rtl/core/pus_pkg.sv */
// Shared types, codes and constants of the pixel unpremultiply and Sub filter block.
`timescale 1ns / 1ps
package pus_pkg;

    localparam int MAX_DIMENSION = 32768;
    localparam int CFG_DATA_W    = 16;
    localparam int CFG_INDEX_W   = 2;
    localparam int QUEUE_DEPTH   = 2;
    localparam int DIV_STEPS     = 16;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ROW_WIDTH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 2'd2;

    // Source pixel formats.
    localparam logic [2:0] FMT_XRGB32    = 3'd0;
    localparam logic [2:0] FMT_ARGB32    = 3'd1;
    localparam logic [2:0] FMT_ARGB32_PM = 3'd2;
    localparam logic [2:0] FMT_RGBX      = 3'd3;
    localparam logic [2:0] FMT_RGBA      = 3'd4;
    localparam logic [2:0] FMT_RGBA_PM   = 3'd5;
    localparam logic [2:0] FMT_RGB888    = 3'd6;
    localparam logic [2:0] FMT_BGR888    = 3'd7;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    // One classified pixel on its way from the front to the back.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       restore;
        logic       row_first;
        logic       row_last;
        logic       image_last;
    } pus_item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_EMIT
    } pus_back_state_t;

endpackage

/* rtl/core/pus_front.sv */
// Front end: configuration registers, input transfer, byte reordering and row position.
`timescale 1ns / 1ps
module pus_front #(
    parameter int MAX_DIMENSION = pus_pkg::MAX_DIMENSION
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pus_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pus_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [31:0]                        s_tdata,
    input  logic                               q_full,
    output logic                               q_push,
    output pus_pkg::pus_item_t                 q_item
);

    localparam int IDX_W = (MAX_DIMENSION > 1) ? $clog2(MAX_DIMENSION) : 1;
    localparam int EFF_W = $clog2(MAX_DIMENSION + 1);
    localparam int CMP_W = pus_pkg::CFG_DATA_W + 1;

    logic [2:0]                      format_reg;
    logic [pus_pkg::CFG_DATA_W-1:0]  width_reg;
    logic [pus_pkg::CFG_DATA_W-1:0]  height_reg;
    logic [IDX_W-1:0]                col_reg, col_next;
    logic [IDX_W-1:0]                row_reg, row_next;
    logic [EFF_W-1:0]                width_eff, height_eff;
    logic                            first, rlast, ilast;
    logic [7:0]                      b0, b1, b2, b3;

    function automatic logic [EFF_W-1:0] eff_size(input logic [pus_pkg::CFG_DATA_W-1:0] v);
        logic [EFF_W-1:0] r;
        if (v == '0) begin
            r = EFF_W'(1);
        end else if ({1'b0, v} > CMP_W'(MAX_DIMENSION)) begin
            r = EFF_W'(MAX_DIMENSION);
        end else begin
            r = EFF_W'(v);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg <= pus_pkg::FMT_XRGB32;
            width_reg  <= pus_pkg::CFG_DATA_W'(1);
            height_reg <= pus_pkg::CFG_DATA_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                pus_pkg::CFG_PIXEL_FORMAT: format_reg <= cfg_data[2:0];
                pus_pkg::CFG_ROW_WIDTH:    width_reg  <= cfg_data;
                pus_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign b0 = s_tdata[7:0];
    assign b1 = s_tdata[15:8];
    assign b2 = s_tdata[23:16];
    assign b3 = s_tdata[31:24];

    assign width_eff  = eff_size(width_reg);
    assign height_eff = eff_size(height_reg);

    // The compare is against the live size, so a shrunken size ends the row at once.
    assign first = (col_reg == '0);
    assign rlast = (EFF_W'(col_reg) + EFF_W'(1)) >= width_eff;
    assign ilast = rlast && ((EFF_W'(row_reg) + EFF_W'(1)) >= height_eff);

    always_comb begin
        q_item.green = b1;
        if (format_reg inside {pus_pkg::FMT_RGBX, pus_pkg::FMT_RGBA,
                               pus_pkg::FMT_RGBA_PM, pus_pkg::FMT_RGB888}) begin
            q_item.red  = b0;
            q_item.blue = b2;
        end else begin
            q_item.red  = b2;
            q_item.blue = b0;
        end
        if (format_reg inside {pus_pkg::FMT_ARGB32, pus_pkg::FMT_ARGB32_PM,
                               pus_pkg::FMT_RGBA, pus_pkg::FMT_RGBA_PM}) begin
            q_item.alpha = b3;
        end else begin
            q_item.alpha = pus_pkg::ALPHA_OPAQUE;
        end
        // Division is needed only when alpha is strictly between 0 and 255.
        q_item.restore = (format_reg inside {pus_pkg::FMT_ARGB32_PM, pus_pkg::FMT_RGBA_PM})
                         && (b3 != 8'd0) && (b3 != pus_pkg::ALPHA_OPAQUE);
        q_item.row_first  = first;
        q_item.row_last   = rlast;
        q_item.image_last = ilast;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_push) begin
            if (rlast) begin
                col_next = '0;
                row_next = ilast ? '0 : row_reg + IDX_W'(1);
            end else begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* rtl/core/pus_queue.sv */
// Short register queue that decouples the front end from the back end.
`timescale 1ns / 1ps
module pus_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pus_pkg::pus_item_t push_item,
    input  logic               pop,
    output pus_pkg::pus_item_t head_item,
    output logic               full,
    output logic               not_empty
);

    localparam int DEPTH = pus_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pus_pkg::pus_item_t slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_item = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + CNT_W'(1);
                2'b01:   count_reg <= count_reg - CNT_W'(1);
                default: ;
            endcase
        end
    end

endmodule

/* rtl/core/pus_divider.sv */
// Three-lane radix-2 restoring divider with a shared 8-bit divisor and clamped quotients.
`timescale 1ns / 1ps
module pus_divider (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [7:0]       divisor,
    input  logic [2:0][15:0] dividend,
    output logic [2:0][7:0]  quotient,
    output logic             done
);

    localparam int CNT_W = $clog2(pus_pkg::DIV_STEPS);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       div_reg;
    logic [2:0][15:0] num_reg;
    logic [2:0][7:0]  rem_reg;
    logic [2:0][15:0] num_next;
    logic [2:0][7:0]  rem_next;

    // One quotient bit per lane each cycle while busy; the partial remainder stays below the divisor.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            logic [8:0] trial;
            trial = {rem_reg[i], num_reg[i][15]};
            if (trial >= {1'b0, div_reg}) begin
                rem_next[i] = 8'(trial - {1'b0, div_reg});
                num_next[i] = {num_reg[i][14:0], 1'b1};
            end else begin
                rem_next[i] = trial[7:0];
                num_next[i] = {num_reg[i][14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            num_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= num_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(pus_pkg::DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            quotient[i] = (num_reg[i][15:8] != '0) ? 8'hFF : num_reg[i][7:0];
        end
    end

    assign done = done_reg;

endmodule

/* rtl/core/pus_back.sv */
// Back end: un-premultiply through the divider, Sub filter and output register.
`timescale 1ns / 1ps
module pus_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  pus_pkg::pus_item_t q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    pus_pkg::pus_back_state_t state_reg, state_next;
    pus_pkg::pus_item_t       work_reg;
    logic [31:0]              prev_reg;
    logic                     m_valid_reg;
    logic [31:0]              m_data_reg;
    logic [1:0]               m_user_reg;
    logic                     m_last_reg;
    logic                     div_start, div_done, out_load;
    logic [2:0][15:0]         dividend;
    logic [2:0][7:0]          quotient;
    logic [7:0]               pr, pg, pb, pa;

    // Rounded restore: c*255 + a/2, formed as (c << 8) - c + (a >> 1).
    always_comb begin
        logic [2:0][7:0] chan;
        chan = {q_head.blue, q_head.green, q_head.red};
        for (int i = 0; i < 3; i++) begin
            dividend[i] = {chan[i], 8'd0} - {8'd0, chan[i]} + {9'd0, q_head.alpha[7:1]};
        end
    end

    pus_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .divisor  (q_head.alpha),
        .dividend (dividend),
        .quotient (quotient),
        .done     (div_done)
    );

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            pus_pkg::BK_IDLE: begin
                if (q_not_empty) begin
                    q_pop      = 1'b1;
                    div_start  = q_head.restore;
                    state_next = q_head.restore ? pus_pkg::BK_DIV : pus_pkg::BK_EMIT;
                end
            end
            pus_pkg::BK_DIV: begin
                if (div_done) begin
                    state_next = pus_pkg::BK_EMIT;
                end
            end
            pus_pkg::BK_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = pus_pkg::BK_IDLE;
                end
            end
            default: state_next = pus_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pus_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            work_reg <= q_head;
        end else if (state_reg == pus_pkg::BK_DIV && div_done) begin
            work_reg.red   <= quotient[0];
            work_reg.green <= quotient[1];
            work_reg.blue  <= quotient[2];
        end
    end

    // The first pixel of a row is filtered against zero.
    assign pr = work_reg.row_first ? 8'd0 : prev_reg[7:0];
    assign pg = work_reg.row_first ? 8'd0 : prev_reg[15:8];
    assign pb = work_reg.row_first ? 8'd0 : prev_reg[23:16];
    assign pa = work_reg.row_first ? 8'd0 : prev_reg[31:24];

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {work_reg.alpha - pa, work_reg.blue - pb,
                           work_reg.green - pg, work_reg.red - pr};
            m_user_reg <= {work_reg.row_last, work_reg.row_first};
            m_last_reg <= work_reg.image_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                prev_reg    <= {work_reg.alpha, work_reg.blue, work_reg.green, work_reg.red};
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == pus_pkg::BK_DIV)
        else $error("divider finished outside the divide state");

    a_div_only_restore: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pus_pkg::BK_DIV) |-> work_reg.restore)
        else $error("divide started for a pixel that needs no restore");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid_reg && state_reg == pus_pkg::BK_IDLE)
        else $error("result load did not present a transfer");

    a_pop_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty && state_reg == pus_pkg::BK_IDLE)
        else $error("queue popped while busy or empty");

endmodule

/* rtl/core/pixel_unpremultiply_sub_filter.sv */
// Top level of the pixel unpremultiply and PNG Sub filter block.
`timescale 1ns / 1ps
// Takes one source pixel per input transfer in the layout chosen by pixel_format,
// turns it into RGBA, restores the colour of premultiplied pixels and emits the
// PNG Sub filtered bytes with row start, row end and image end flags. A pixel
// that needs un-premultiplying (premultiplied format, alpha neither 0 nor 255)
// occupies the back end through queue pop, the 16-step shared radix-2 divider,
// result capture and output load; every other pixel goes from queue pop
// straight to output load. A two-entry queue lets the input accept while the
// back end divides, and the output register holds a result while the next is
// worked on. Configuration writes take effect on the next pixel accepted.
module pixel_unpremultiply_sub_filter #(
    parameter int MAX_DIMENSION = pus_pkg::MAX_DIMENSION
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [pus_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pus_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // byte0, byte1, byte2, byte3
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,  // red_out, green_out, blue_out, alpha_out
    output logic [1:0]                      m_tuser,  // row_first, row_last
    output logic                            m_tlast   // image_last
);

    pus_pkg::pus_item_t push_item, head_item;
    logic               q_push, q_pop, q_full, q_not_empty;

    pus_front #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    pus_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    pus_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (head_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule
